>>> hdl/sobel_gradient_nonmax_suppression_core_assert.svh
// assertion macros for the edge core
`ifndef SOBEL_GRADIENT_NONMAX_SUPPRESSION_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_NONMAX_SUPPRESSION_CORE_ASSERT_SVH

// same-cycle implication
`define SGNMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGNMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sgnms_pkg.sv
`timescale 1ns / 1ps
package sgnms_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int ROW_W         = 11;
  localparam int PIX_W         = 8;
  localparam int GRAD_W        = 11;
  localparam int ACC_W         = 12;
  localparam int SQ_W          = 2 * GRAD_W;
  localparam int ROOT_W        = 11;
  localparam int DIR_W         = 30;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [DIR_W-1:0] TAN22_Q16 = DIR_W'(27146);
  localparam logic [DIR_W-1:0] TAN67_Q16 = DIR_W'(158218);

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] operand;
  } sgnms_sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sgnms_sqrt_rsp_t;

  // neighbor k of the 3x3 window, center left out
  function automatic logic signed [2:0] nb_dr(input logic [2:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = -3'sd1;
      3'd3, 3'd4:       d = 3'sd0;
      default:          d = 3'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] nb_dc(input logic [2:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = -3'sd1;
      3'd1, 3'd6:       d = 3'sd0;
      default:          d = 3'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] coef_gx(input logic [2:0] k);
    logic signed [2:0] c;
    unique case (k)
      3'd0, 3'd5: c = -3'sd1;
      3'd1, 3'd6: c = 3'sd0;
      3'd2, 3'd7: c = 3'sd1;
      3'd3:       c = -3'sd2;
      default:    c = 3'sd2;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] coef_gy(input logic [2:0] k);
    logic signed [2:0] c;
    unique case (k)
      3'd0, 3'd2: c = -3'sd1;
      3'd1:       c = -3'sd2;
      3'd3, 3'd4: c = 3'sd0;
      3'd5, 3'd7: c = 3'sd1;
      default:    c = 3'sd2;
    endcase
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] scale(input logic signed [2:0] c,
                                                    input logic [PIX_W-1:0] p);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] r;
    v = signed'(ACC_W'(p));
    unique case (c)
      3'sd1:   r = v;
      3'sd2:   r = v <<< 1;
      -3'sd1:  r = -v;
      -3'sd2:  r = -(v <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mod3_add(input logic [1:0] m, input logic signed [2:0] d);
    logic [1:0] r;
    if (d > 0) begin
      r = (m == 2'd2) ? 2'd0 : m + 2'd1;
    end else if (d < 0) begin
      r = (m == 2'd0) ? 2'd2 : m - 2'd1;
    end else begin
      r = m;
    end
    return r;
  endfunction

endpackage

>>> hdl/sgnms_if.sv
`timescale 1ns / 1ps
interface sgnms_in_if;
  import sgnms_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output command, output pixel_in, input ready);
  modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface sgnms_out_if;
  import sgnms_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             frame_last;
  modport source (output valid, output edge_value, output frame_last, input ready);
  modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface

>>> hdl/sgnms_ram.sv
`timescale 1ns / 1ps
module sgnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/sgnms_isqrt.sv
`timescale 1ns / 1ps
module sgnms_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sgnms_pkg::sgnms_sqrt_req_t req,
  output sgnms_pkg::sgnms_sqrt_rsp_t rsp
);
  import sgnms_pkg::*;

  localparam int RW = ROOT_W + 3;
  localparam int CW = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   op_r, op_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;

  // one root bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem_r[RW-3:0], op_r[SQ_W-1:SQ_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      op_nxt   = req.operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      op_nxt = op_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r   <= op_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;
endmodule

>>> hdl/sobel_gradient_nonmax_suppression_core.sv
`timescale 1ns / 1ps
// Sobel edge core with non-maximum suppression on an 8-bit grayscale raster.
// in_ch carries one transaction per pixel (command 0) or a flush tick (command 1).
// out_ch returns the edge value of each pixel in raster order; frame_last marks the
// final pixel of a frame. Outputs trail the input by 2*width+3 pixels; once a full
// frame is in, each transaction (flush ticks included) drains one pending pixel.
// The cfg port sets image_width (index 0) and image_height (index 1); a write also
// restarts the frame. Write only while the core is idle.
// One transaction is processed at a time. A transaction that yields no result passes
// through the write and check states only. A result adds a gradient loop with 8 pixel
// memory reads per gradient computed, one gradient in steady state and width+2
// for the first pixel of a frame; then a border pixel is emitted directly, while for
// an interior pixel the shared square root unit (11 iterations) runs two times if it
// is suppressed and three times if it is kept.
// Reset (synchronous, rst_n low) returns the sizes to 640x480 and all positions to
// the start of a frame; the line stores need no clearing.
// A finished result sits in the output register; the next transaction is accepted
// meanwhile, and a new result waits until the receiver has taken the previous one.
module sobel_gradient_nonmax_suppression_core #(
  parameter int MAX_WIDTH = sgnms_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sgnms_in_if.sink                        in_ch,
  sgnms_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [sgnms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgnms_pkg::CFG_W-1:0]     cfg_wdata
);
  import sgnms_pkg::*;

  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int WX    = (WW > CFG_W) ? WW : CFG_W;
  localparam int PW    = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 2 * MAX_WIDTH + 4);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_WR    = 5'd1;
  localparam logic [4:0] ST_CHK   = 5'd2;
  localparam logic [4:0] ST_GCHK  = 5'd3;
  localparam logic [4:0] ST_GRD   = 5'd4;
  localparam logic [4:0] ST_GWR   = 5'd5;
  localparam logic [4:0] ST_OUT   = 5'd6;
  localparam logic [4:0] ST_PB    = 5'd7;
  localparam logic [4:0] ST_C1    = 5'd8;
  localparam logic [4:0] ST_SQ    = 5'd9;
  localparam logic [4:0] ST_DIRM  = 5'd10;
  localparam logic [4:0] ST_DIR   = 5'd11;
  localparam logic [4:0] ST_NRD   = 5'd12;
  localparam logic [4:0] ST_NLAT  = 5'd13;
  localparam logic [4:0] ST_NSQ   = 5'd14;
  localparam logic [4:0] ST_NSUM  = 5'd15;
  localparam logic [4:0] ST_NSQRT = 5'd16;
  localparam logic [4:0] ST_NCMP  = 5'd17;
  localparam logic [4:0] ST_VSQ   = 5'd18;
  localparam logic [4:0] ST_VWAIT = 5'd19;
  localparam logic [4:0] ST_EMIT  = 5'd20;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                              input logic [WW-1:0] col);
    logic [AW-1:0] base;
    unique case (slot)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_WIDTH);
      default: base = AW'(2 * MAX_WIDTH);
    endcase
    return base + AW'(col[CIW-1:0]);
  endfunction

  function automatic logic [WW-1:0] col_off(input logic [WW-1:0] c,
                                            input logic signed [2:0] d);
    logic [WW-1:0] r;
    if (d > 0) begin
      r = c + WW'(1);
    end else if (d < 0) begin
      r = c - WW'(1);
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [4:0]               state_r, state_nxt;
  logic                     cmd_r, cmd_nxt;
  logic [PIX_W-1:0]         pix_r, pix_nxt;
  logic [CFG_W-1:0]         iw_r, iw_nxt, ih_r, ih_nxt;
  logic [WW-1:0]            w_r, w_nxt;
  logic [ROW_W-1:0]         h_r, h_nxt;
  logic [PW-1:0]            total_r, total_nxt;
  logic [PW-1:0]            recv_r, recv_nxt;
  logic [ROW_W-1:0]         irow_r, irow_nxt;
  logic [WW-1:0]            icol_r, icol_nxt;
  logic [1:0]               imod_r, imod_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [ROW_W-1:0]         prow_r, prow_nxt;
  logic [WW-1:0]            pcol_r, pcol_nxt;
  logic [1:0]               pmod_r, pmod_nxt;
  logic [PW-1:0]            gpos_r, gpos_nxt;
  logic [ROW_W-1:0]         grow_r, grow_nxt;
  logic [WW-1:0]            gcol_r, gcol_nxt;
  logic [1:0]               gmod_r, gmod_nxt;
  logic [PW-1:0]            hi_r, hi_nxt;
  logic [3:0]               k_r, k_nxt;
  logic [2:0]               kd_r, kd_nxt;
  logic                     zf_r, zf_nxt;
  logic                     rdv_r, rdv_nxt;
  logic signed [ACC_W-1:0]  accx_r, accx_nxt, accy_r, accy_nxt;
  logic signed [GRAD_W-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic signed [ACC_W-1:0]  fx_r, fx_nxt, fy_r, fy_nxt;
  logic [SQ_W-1:0]          s_r, s_nxt;
  logic [DIR_W-1:0]         t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [2:0]        dr1_r, dr1_nxt, dc1_r, dc1_nxt;
  logic                     nb_r, nb_nxt;
  logic [SQ_W-1:0]          m2_r, m2_nxt;
  logic                     keep_r, keep_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]         out_val_r, out_val_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [PIX_W-1:0]         val_r, val_nxt;

  logic [WX-1:0]            iw_x;
  logic [PW-1:0]            lim;
  logic signed [2:0]        kdr, kdc, ndr, ndc;
  logic                     row_ok, col_ok;
  logic signed [SQ_W-1:0]   px, py;
  logic [ACC_W-2:0]         ax;
  logic [DIR_W-1:0]         a_val;
  logic [SQ_W-1:0]          root_sq;

  logic                     pm_we, gm_we;
  logic [AW-1:0]            pm_waddr, pm_raddr, gm_waddr, gm_raddr;
  logic [PIX_W-1:0]         pm_wdata, pm_rdata;
  logic [SQ_W-1:0]          gm_wdata, gm_rdata;

  sgnms_sqrt_req_t sq_req;
  sgnms_sqrt_rsp_t sq_rsp;

  sgnms_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  sgnms_ram #(.WIDTH(SQ_W), .DEPTH(DEPTH)) u_grad_ram (
    .clk   (clk),
    .we    (gm_we),
    .waddr (gm_waddr),
    .wdata (gm_wdata),
    .raddr (gm_raddr),
    .rdata (gm_rdata)
  );

  sgnms_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pix_nxt       = pix_r;
    iw_nxt        = iw_r;
    ih_nxt        = ih_r;
    recv_nxt      = recv_r;
    irow_nxt      = irow_r;
    icol_nxt      = icol_r;
    imod_nxt      = imod_r;
    pos_nxt       = pos_r;
    prow_nxt      = prow_r;
    pcol_nxt      = pcol_r;
    pmod_nxt      = pmod_r;
    gpos_nxt      = gpos_r;
    grow_nxt      = grow_r;
    gcol_nxt      = gcol_r;
    gmod_nxt      = gmod_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    kd_nxt        = kd_r;
    zf_nxt        = zf_r;
    rdv_nxt       = 1'b0;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    s_nxt         = s_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    dr1_nxt       = dr1_r;
    dc1_nxt       = dc1_r;
    nb_nxt        = nb_r;
    m2_nxt        = m2_r;
    keep_nxt      = keep_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    pm_we    = 1'b0;
    pm_waddr = slot_addr(imod_r, icol_r);
    pm_wdata = pix_r;
    pm_raddr = slot_addr(pmod_r, pcol_r);
    gm_we    = 1'b0;
    gm_waddr = slot_addr(gmod_r, gcol_r);
    gm_wdata = {accy_r[GRAD_W-1:0], accx_r[GRAD_W-1:0]};
    gm_raddr = slot_addr(pmod_r, pcol_r);
    sq_req.start   = 1'b0;
    sq_req.operand = s_r;

    // clamp the frame size
    iw_x  = WX'(iw_r);
    if (iw_x < WX'(3)) begin
      w_nxt = WW'(3);
    end else if (iw_x > WX'(MAX_WIDTH)) begin
      w_nxt = WW'(MAX_WIDTH);
    end else begin
      w_nxt = WW'(iw_x);
    end
    if (ih_r < CFG_W'(3)) begin
      h_nxt = ROW_W'(3);
    end else if (ih_r > CFG_W'(HEIGHT_LIMIT)) begin
      h_nxt = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_nxt = ROW_W'(ih_r);
    end
    total_nxt = PW'(PW'(w_r) * PW'(h_r));

    lim   = pos_r + PW'(w_r) + PW'(1);
    kdr   = nb_dr(k_r[2:0]);
    kdc   = nb_dc(k_r[2:0]);
    ndr   = nb_r ? -dr1_r : dr1_r;
    ndc   = nb_r ? -dc1_r : dc1_r;
    row_ok = (kdr == 3'sd0) || ((kdr < 0) && (grow_r != '0)) ||
             ((kdr > 0) && (({1'b0, grow_r} + (ROW_W + 1)'(1)) < {1'b0, h_r}));
    col_ok = (kdc == 3'sd0) || ((kdc < 0) && (gcol_r != '0)) ||
             ((kdc > 0) && (({1'b0, gcol_r} + (WW + 1)'(1)) < {1'b0, w_r}));
    px      = gx_r * gx_r;
    py      = gy_r * gy_r;
    ax      = (fx_r < 0) ? (ACC_W - 1)'(-fx_r) : fx_r[ACC_W-2:0];
    a_val   = DIR_W'({fy_r[ACC_W-2:0], 16'h0000});
    root_sq = SQ_W'(sq_rsp.root) * SQ_W'(sq_rsp.root);

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          pix_nxt   = in_ch.pixel_in;
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        if (cmd_r == CMD_PIXEL && irow_r < h_r) begin
          pm_we    = 1'b1;
          recv_nxt = recv_r + PW'(1);
          if (icol_r + WW'(1) >= w_r) begin
            icol_nxt = '0;
            irow_nxt = irow_r + ROW_W'(1);
            imod_nxt = mod3_add(imod_r, 3'sd1);
          end else begin
            icol_nxt = icol_r + WW'(1);
          end
        end
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (recv_r >= total_r ||
            recv_r >= pos_r + PW'({w_r, 1'b0}) + PW'(3)) begin
          hi_nxt    = (lim > total_r - PW'(1)) ? total_r - PW'(1) : lim;
          state_nxt = ST_GCHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GCHK: begin
        if (gpos_r <= hi_r) begin
          k_nxt     = '0;
          accx_nxt  = '0;
          accy_nxt  = '0;
          state_nxt = ST_GRD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_GRD: begin
        // issue one window read per cycle, accumulate the one before
        pm_raddr = slot_addr(mod3_add(gmod_r, kdr), col_off(gcol_r, kdc));
        if (!k_r[3]) begin
          zf_nxt  = !(row_ok && col_ok);
          kd_nxt  = k_r[2:0];
          rdv_nxt = 1'b1;
          k_nxt   = k_r + 4'd1;
        end else begin
          state_nxt = ST_GWR;
        end
        if (rdv_r && !zf_r) begin
          accx_nxt = accx_r + scale(coef_gx(kd_r), pm_rdata);
          accy_nxt = accy_r + scale(coef_gy(kd_r), pm_rdata);
        end
      end
      ST_GWR: begin
        gm_we    = 1'b1;
        gpos_nxt = gpos_r + PW'(1);
        if (gcol_r + WW'(1) >= w_r) begin
          gcol_nxt = '0;
          grow_nxt = grow_r + ROW_W'(1);
          gmod_nxt = mod3_add(gmod_r, 3'sd1);
        end else begin
          gcol_nxt = gcol_r + WW'(1);
        end
        state_nxt = ST_GCHK;
      end
      ST_OUT: begin
        if (prow_r == '0 || pcol_r == '0 || prow_r == h_r - ROW_W'(1) ||
            pcol_r == w_r - WW'(1)) begin
          state_nxt = ST_PB;
        end else begin
          state_nxt = ST_C1;
        end
      end
      ST_PB: begin
        val_nxt   = pm_rdata;
        state_nxt = ST_EMIT;
      end
      ST_C1: begin
        gx_nxt    = signed'(gm_rdata[GRAD_W-1:0]);
        gy_nxt    = signed'(gm_rdata[SQ_W-1:GRAD_W]);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        sqx_nxt = SQ_W'(px);
        sqy_nxt = SQ_W'(py);
        if (gy_r < 0) begin
          fx_nxt = -ACC_W'(gx_r);
          fy_nxt = -ACC_W'(gy_r);
        end else begin
          fx_nxt = ACC_W'(gx_r);
          fy_nxt = ACC_W'(gy_r);
        end
        state_nxt = ST_DIRM;
      end
      ST_DIRM: begin
        s_nxt     = sqx_r + sqy_r;
        t1_nxt    = DIR_W'(TAN22_Q16 * DIR_W'(ax));
        t2_nxt    = DIR_W'(TAN67_Q16 * DIR_W'(ax));
        state_nxt = ST_DIR;
      end
      ST_DIR: begin
        if (fy_r == '0 || a_val < t1_r) begin
          dr1_nxt = 3'sd0;
          dc1_nxt = -3'sd1;
        end else if (a_val < t2_r) begin
          dr1_nxt = -3'sd1;
          dc1_nxt = (fx_r > 0) ? -3'sd1 : 3'sd1;
        end else begin
          dr1_nxt = -3'sd1;
          dc1_nxt = 3'sd0;
        end
        nb_nxt    = 1'b0;
        keep_nxt  = 1'b1;
        state_nxt = ST_NRD;
      end
      ST_NRD: begin
        gm_raddr  = slot_addr(mod3_add(pmod_r, ndr), col_off(pcol_r, ndc));
        state_nxt = ST_NLAT;
      end
      ST_NLAT: begin
        gx_nxt    = signed'(gm_rdata[GRAD_W-1:0]);
        gy_nxt    = signed'(gm_rdata[SQ_W-1:GRAD_W]);
        state_nxt = ST_NSQ;
      end
      ST_NSQ: begin
        sqx_nxt   = SQ_W'(px);
        sqy_nxt   = SQ_W'(py);
        state_nxt = ST_NSUM;
      end
      ST_NSUM: begin
        sq_req.start   = 1'b1;
        sq_req.operand = sqx_r + sqy_r;
        state_nxt      = ST_NSQRT;
      end
      ST_NSQRT: begin
        if (sq_rsp.done) begin
          m2_nxt    = root_sq;
          state_nxt = ST_NCMP;
        end
      end
      ST_NCMP: begin
        if (!(s_r > m2_r)) begin
          keep_nxt = 1'b0;
        end
        if (nb_r) begin
          state_nxt = ST_VSQ;
        end else begin
          nb_nxt    = 1'b1;
          state_nxt = ST_NRD;
        end
      end
      ST_VSQ: begin
        if (keep_r) begin
          sq_req.start = 1'b1;
          state_nxt    = ST_VWAIT;
        end else begin
          val_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_VWAIT: begin
        if (sq_rsp.done) begin
          val_nxt   = (sq_rsp.root > ROOT_W'(255)) ? PIX_W'(255) : PIX_W'(sq_rsp.root);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = val_r;
          state_nxt     = ST_IDLE;
          if (pos_r == total_r - PW'(1)) begin
            out_last_nxt = 1'b1;
            recv_nxt = '0;
            irow_nxt = '0;
            icol_nxt = '0;
            imod_nxt = '0;
            pos_nxt  = '0;
            prow_nxt = '0;
            pcol_nxt = '0;
            pmod_nxt = '0;
            gpos_nxt = '0;
            grow_nxt = '0;
            gcol_nxt = '0;
            gmod_nxt = '0;
          end else begin
            out_last_nxt = 1'b0;
            pos_nxt      = pos_r + PW'(1);
            if (pcol_r + WW'(1) >= w_r) begin
              pcol_nxt = '0;
              prow_nxt = prow_r + ROW_W'(1);
              pmod_nxt = mod3_add(pmod_r, 3'sd1);
            end else begin
              pcol_nxt = pcol_r + WW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  iw_nxt = cfg_wdata;
        REG_IMAGE_HEIGHT: ih_nxt = cfg_wdata;
        default:          iw_nxt = iw_r;
      endcase
      recv_nxt = '0;
      irow_nxt = '0;
      icol_nxt = '0;
      imod_nxt = '0;
      pos_nxt  = '0;
      prow_nxt = '0;
      pcol_nxt = '0;
      pmod_nxt = '0;
      gpos_nxt = '0;
      grow_nxt = '0;
      gcol_nxt = '0;
      gmod_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iw_r        <= WIDTH_RESET;
      ih_r        <= HEIGHT_RESET;
      w_r         <= WW'(3);
      h_r         <= ROW_W'(3);
      total_r     <= PW'(9);
      recv_r      <= '0;
      irow_r      <= '0;
      icol_r      <= '0;
      imod_r      <= '0;
      pos_r       <= '0;
      prow_r      <= '0;
      pcol_r      <= '0;
      pmod_r      <= '0;
      gpos_r      <= '0;
      grow_r      <= '0;
      gcol_r      <= '0;
      gmod_r      <= '0;
      hi_r        <= '0;
      k_r         <= '0;
      rdv_r       <= 1'b0;
      nb_r        <= 1'b0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iw_r        <= iw_nxt;
      ih_r        <= ih_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      total_r     <= total_nxt;
      recv_r      <= recv_nxt;
      irow_r      <= irow_nxt;
      icol_r      <= icol_nxt;
      imod_r      <= imod_nxt;
      pos_r       <= pos_nxt;
      prow_r      <= prow_nxt;
      pcol_r      <= pcol_nxt;
      pmod_r      <= pmod_nxt;
      gpos_r      <= gpos_nxt;
      grow_r      <= grow_nxt;
      gcol_r      <= gcol_nxt;
      gmod_r      <= gmod_nxt;
      hi_r        <= hi_nxt;
      k_r         <= k_nxt;
      rdv_r       <= rdv_nxt;
      nb_r        <= nb_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    pix_r      <= pix_nxt;
    kd_r       <= kd_nxt;
    zf_r       <= zf_nxt;
    accx_r     <= accx_nxt;
    accy_r     <= accy_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    s_r        <= s_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    dr1_r      <= dr1_nxt;
    dc1_r      <= dc1_nxt;
    m2_r       <= m2_nxt;
    val_r      <= val_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_value = out_val_r;
  assign out_ch.frame_last = out_last_r;

  `include "sobel_gradient_nonmax_suppression_core_assert.svh"

  `SGNMS_ASSERT_IMP(a_emit_in_frame, state_r == ST_EMIT, pos_r < total_r, "output position past frame end")
  `SGNMS_ASSERT_IMP(a_grad_bounded, state_r == ST_GRD, gpos_r <= hi_r, "gradient computed ahead of window")
  `SGNMS_ASSERT_IMP(a_sqrt_free, sq_req.start, !sq_rsp.busy, "square root started while busy")
  `SGNMS_ASSERT_NXT(a_emit_loads, (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready), out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule

>>> sim/sgnms_tb_if.sv
`timescale 1ns / 1ps
interface sgnms_cfg_if;
  import sgnms_pkg::*;
  logic                 we;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     wdata;
endinterface

>>> sim/sgnms_checker.sv
`timescale 1ns / 1ps
module sgnms_checker
  import sgnms_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  sgnms_in_if            in_ch,
  sgnms_out_if           out_ch,
  sgnms_cfg_if           cfg,
  output int             fail_count,
  output int             pending_count
);

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } edge_result_t;

  localparam int MW = MAX_WIDTH_DEF;

  int unsigned width_reg, height_reg;
  logic [7:0]  pix_mem [3*MW];
  int          gx_mem [3*MW];
  int          gy_mem [3*MW];
  int unsigned col_pos, row_pos, out_pos;
  edge_result_t expected_q[$];

  function automatic int unsigned slot(int r, int c);
    return (r % 3) * MW + (c % MW);
  endfunction

  function automatic int pixel_at(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return pix_mem[slot(r, c)];
  endfunction

  function automatic int unsigned floor_sqrt(longint unsigned s);
    int unsigned x;
    x = 0;
    while ((longint'(x) + 1) * (x + 1) <= s) x++;
    return x;
  endfunction

  function automatic void store_gradient(int r, int c, int w, int h);
    int a, b, d, e, f, g, k, m, gx, gy;
    a = pixel_at(r-1, c-1, w, h); b = pixel_at(r-1, c, w, h); d = pixel_at(r-1, c+1, w, h);
    e = pixel_at(r, c-1, w, h);   f = pixel_at(r, c+1, w, h);
    g = pixel_at(r+1, c-1, w, h); k = pixel_at(r+1, c, w, h); m = pixel_at(r+1, c+1, w, h);
    gx = (d - a) + 2 * (f - e) + (m - g);
    gy = (g + 2 * k + m) - (a + 2 * b + d);
    gx_mem[slot(r, c)] = gx;
    gy_mem[slot(r, c)] = gy;
  endfunction

  function automatic longint unsigned energy(int r, int c);
    return longint'(gx_mem[slot(r, c)]) * gx_mem[slot(r, c)]
         + longint'(gy_mem[slot(r, c)]) * gy_mem[slot(r, c)];
  endfunction

  function automatic int unsigned suppressed(int r, int c);
    int gx, gy, dr, dc;
    longint unsigned s, m1, m2, a, ax;
    int unsigned v;
    gx = gx_mem[slot(r, c)];
    gy = gy_mem[slot(r, c)];
    s = energy(r, c);
    if (gy < 0) begin
      gx = -gx;
      gy = -gy;
    end
    ax = (gx < 0) ? -gx : gx;
    a = longint'(gy) << 16;
    if (gy == 0 || a < 27146 * ax) begin
      dr = 0; dc = -1;
    end else if (a < 158218 * ax) begin
      dr = -1; dc = (gx > 0) ? -1 : 1;
    end else begin
      dr = -1; dc = 0;
    end
    m1 = floor_sqrt(energy(r + dr, c + dc));
    m2 = floor_sqrt(energy(r - dr, c - dc));
    if (!(s > m1 * m1 && s > m2 * m2)) return 0;
    v = floor_sqrt(s);
    return (v > 255) ? 255 : v;
  endfunction

  task automatic predict_edge(input logic cmd, input logic [7:0] px);
    int unsigned w, h, total, recv, p, lo, hi, q, val;
    int r, c;
    edge_result_t res;
    w = (width_reg < 3) ? 3 : (width_reg > MW ? MW : width_reg);
    h = (height_reg < 3) ? 3 : (height_reg > 1024 ? 1024 : height_reg);
    total = w * h;
    if (cmd == CMD_PIXEL && row_pos < h && col_pos < w) begin
      pix_mem[(row_pos % 3) * MW + col_pos] = px;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    recv = row_pos * w + col_pos;
    p = out_pos;
    if (p >= total) p = 0;
    if (!(recv >= total || recv >= p + 2 * w + 3)) return;
    hi = p + w + 1;
    if (hi > total - 1) hi = total - 1;
    lo = (p == 0) ? 0 : p + w + 1;
    for (q = lo; q <= hi; q++) store_gradient(q / w, q % w, w, h);
    r = p / w;
    c = p % w;
    if (r == 0 || c == 0 || r == h - 1 || c == w - 1) val = pixel_at(r, c, w, h);
    else val = suppressed(r, c);
    res.edge_value = val[7:0];
    res.frame_last = (p == total - 1);
    if (p == total - 1) begin
      col_pos = 0; row_pos = 0; out_pos = 0;
    end else begin
      out_pos = p + 1;
    end
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    edge_result_t exp_r;
    if (!rst_n) begin
      width_reg = 640;
      height_reg = 480;
      col_pos = 0; row_pos = 0; out_pos = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.we) begin
        if (cfg.index == REG_IMAGE_WIDTH) width_reg = cfg.wdata;
        else height_reg = cfg.wdata;
        col_pos = 0; row_pos = 0; out_pos = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: edge_value %0d", out_ch.edge_value);
          fail_count = fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.edge_value !== out_ch.edge_value) begin
            $error("edge_value expected %0d actual %0d", exp_r.edge_value, out_ch.edge_value);
            fail_count = fail_count + 1;
          end
          if (exp_r.frame_last !== out_ch.frame_last) begin
            $error("frame_last expected %0d actual %0d", exp_r.frame_last, out_ch.frame_last);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_edge(in_ch.command, in_ch.pixel_in);
    end
    pending_count = expected_q.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sgnms_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_idle_pct;
  int   idle_cycles;

  sgnms_in_if  in_ch ();
  sgnms_out_if out_ch ();
  sgnms_cfg_if cfg ();

  always #10 clk = ~clk;

  sobel_gradient_nonmax_suppression_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata)
  );

  sgnms_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PIXEL;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
    cfg.we = 1'b0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.wdata = '0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] px);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pixel_in <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg.we <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= CFG_W'(val);
    @(posedge clk);
    cfg.we <= 1'b0;
    @(posedge clk);
  endtask

  // full frame of pixels with random flush ticks mixed in, then flush ticks or surplus pixels until the frame drains
  task automatic send_frame(input int w, input int h, input int style);
    int i;
    logic [7:0] px;
    for (i = 0; i < w * h; i++) begin
      case (style)
        0: px = 8'($urandom);
        1: px = (i % 2) ? 8'hff : 8'h00;
        2: px = ((i / w) > h / 2) ? 8'hff : 8'h00;
        3: px = ((i % w) > w / 2) ? 8'h00 : 8'hff;
        default: px = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(i * 7);
      endcase
      if ($urandom_range(19) == 0) send_item(CMD_FLUSH, 8'($urandom));
      send_item(CMD_PIXEL, px);
    end
    for (i = 0; i < 2 * w + 3; i++) send_item(1'($urandom_range(1)), 8'($urandom));
    drain_results();
  endtask

  initial begin
    int sent, w, h, ph;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flush with nothing pending, then extremes
    send_item(CMD_FLUSH, 8'hff);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_frame(3, 3, 1);
    send_frame(3, 3, 0);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 2047);
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_frame(3, 3, 2);
    // abandoned partial frame
    write_reg(REG_IMAGE_WIDTH, 5);
    write_reg(REG_IMAGE_HEIGHT, 4);
    repeat (6) send_item(CMD_PIXEL, 8'($urandom));
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 5);
    send_frame(5, 4, 3);

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 24 : 0;
      sent = 0;
      while (sent < 330) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
        h = $urandom_range(3, 8);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        send_frame(w, h, $urandom_range(4));
        sent += w * h;
      end
    end
    // oversized frame clamps to the widest row
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 1024);
    send_item(CMD_PIXEL, 8'h55);
    drain_results();

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
